// ===== sv/systematic_weight_comb_top_assert.svh =====
// Assertion macros for the systematic weight comb block
`ifndef SYSTEMATIC_WEIGHT_COMB_TOP_ASSERT_SVH
`define SYSTEMATIC_WEIGHT_COMB_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SWC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWC_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/swc_pkg.sv =====
// Types, constants and codes shared by the systematic weight comb modules
package swc_pkg;

  localparam int unsigned MaxEntriesDef = 1024;
  localparam int unsigned MaxTeethDef   = 64;

  localparam int unsigned WeightW = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned StepW   = 42;
  localparam int unsigned ThrW    = StepW + 1;
  localparam int unsigned ProdW   = StepW + FracW;
  localparam int unsigned TeethW  = 7;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned StatusW = 2;

  localparam logic [TeethW-1:0] TeethReset = TeethW'(64);
  localparam logic [StepW-1:0]  TotalMax   = {StepW{1'b1}};

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StOvf   = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL,
    S_INIT,
    S_RD,
    S_ADD,
    S_CMP,
    S_FILL,
    S_EMPTY
  } state_e;

  typedef enum logic [1:0] {
    EMIT_WALK,
    EMIT_REPEAT,
    EMIT_EMPTY
  } emit_e;

  typedef struct packed {
    logic  accept;
    logic  clr_set;
    logic  div_start;
    logic  mul;
    logic  walk_init;
    logic  rd;
    logic  add;
    logic  emit;
    emit_e kind;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic teeth_zero;
    logic total_zero;
    logic div_busy;
    logic rd_more;
    logic tooth_lt;
    logic tooth_zero;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swc_if.sv =====
// Request channel interfaces: weight input, result output, teeth configuration
interface swc_in_if;
  logic                         valid;
  logic                         ready;
  logic [swc_pkg::WeightW-1:0]  weight;
  logic [swc_pkg::FracW-1:0]    random_fraction;
  logic                         last_item;

  modport source (output valid, weight, random_fraction, last_item, input ready);
  modport sink   (input valid, weight, random_fraction, last_item, output ready);
endinterface

interface swc_out_if;
  logic                         valid;
  logic                         ready;
  logic [swc_pkg::IdxOutW-1:0]  source_index;
  logic [swc_pkg::StepW-1:0]    tooth_weight;
  logic                         last_result;
  logic [swc_pkg::StatusW-1:0]  status;

  modport source (output valid, source_index, tooth_weight, last_result, status,
                  input ready);
  modport sink   (input valid, source_index, tooth_weight, last_result, status,
                  output ready);
endinterface

interface swc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swc_pkg::TeethW-1:0]   teeth_count;

  modport source (output valid, teeth_count, input ready);
  modport sink   (input valid, teeth_count, output ready);
endinterface

// ===== sv/systematic_weight_comb_top.sv =====
// Weights load at one per cycle into the store while in the load state; no result until
// the last item. After the last item: a check, serial division (one quotient bit a
// cycle), the offset multiply, then a walk over the stored entries that emits the teeth,
// stalled by the output's ready. A new set is taken after the final result enters the
// output register, once the controller is back in its load state.
// Reset is asynchronous: count, total, overflow mark and teeth (64) reset; store is not cleared.
module systematic_weight_comb_top #(
  parameter int unsigned MAX_ENTRIES = swc_pkg::MaxEntriesDef,
  parameter int unsigned MAX_TEETH   = swc_pkg::MaxTeethDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swc_in_if.sink     in_i,
  swc_out_if.source  out_o,
  swc_cfg_if.sink    cfg_i
);

  swc_pkg::cmd_t cmd;
  swc_pkg::sts_t sts;

  swc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  swc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_TEETH   (MAX_TEETH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ===== sv/swc_div.sv =====
// Serial restoring divider: total by tooth count, one quotient bit per cycle
module swc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swc_pkg::StepW-1:0]   dividend_i,
  input  logic [swc_pkg::TeethW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [swc_pkg::StepW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(swc_pkg::StepW);

  logic [swc_pkg::StepW-1:0]  dvd_q;
  logic [swc_pkg::TeethW-1:0] rem_q;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q;

  logic [swc_pkg::TeethW:0]   rem_sh;
  logic                       ge;
  logic [swc_pkg::TeethW:0]   rem_sub;

  assign rem_sh  = {rem_q, dvd_q[swc_pkg::StepW-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(swc_pkg::StepW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[swc_pkg::StepW-2:0], ge};
      rem_q <= ge ? rem_sub[swc_pkg::TeethW-1:0] : rem_sh[swc_pkg::TeethW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

// ===== sv/swc_dp.sv =====
// Datapath: weight store, running total, step and offset, comb walk, output register
`include "systematic_weight_comb_top_assert.svh"

module swc_dp #(
  parameter int unsigned MAX_ENTRIES = swc_pkg::MaxEntriesDef,
  parameter int unsigned MAX_TEETH   = swc_pkg::MaxTeethDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  swc_in_if.sink         in_i,
  swc_out_if.source      out_o,
  swc_cfg_if.sink        cfg_i,
  input  swc_pkg::cmd_t  cmd_i,
  output swc_pkg::sts_t  sts_o
);

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW   = (CntW > swc_pkg::IdxOutW) ? CntW : swc_pkg::IdxOutW;

  logic [swc_pkg::WeightW-1:0] mem_q [MAX_ENTRIES];
  logic [swc_pkg::WeightW-1:0] rdata_q;

  logic [swc_pkg::TeethW-1:0]  teeth_cfg_q;
  logic [CntW-1:0]             count_q;
  logic [swc_pkg::StepW-1:0]   total_q;
  logic                        ovf_q;
  logic [swc_pkg::FracW-1:0]   frac_q;
  logic [swc_pkg::StepW-1:0]   step_q;
  logic [swc_pkg::ProdW-1:0]   prod_q;
  logic [swc_pkg::ThrW-1:0]    thr_q;
  logic [swc_pkg::ThrW-1:0]    cum_q;
  logic [CntW-1:0]             rd_idx_q;
  logic [CntW-1:0]             sel_q;
  logic [swc_pkg::TeethW-1:0]  tooth_q;

  logic                        out_valid_q;
  logic [swc_pkg::IdxOutW-1:0] out_idx_q;
  logic [swc_pkg::StepW-1:0]   out_w_q;
  logic                        out_last_q;
  logic [swc_pkg::StatusW-1:0] out_st_q;

  logic                        fire;
  logic                        full;
  logic [swc_pkg::TeethW-1:0]  teeth_sat;
  logic [swc_pkg::StepW:0]     tsum;
  logic [swc_pkg::StepW-1:0]   total_d;
  logic [swc_pkg::ThrW:0]      csum;
  logic [swc_pkg::ThrW-1:0]    cum_d;
  logic [swc_pkg::StepW-1:0]   quot;
  logic                        div_busy;
  logic [IW-1:0]               sel_wide;
  logic                        out_free;
  logic                        last_tooth;

  assign fire      = in_i.valid && cmd_i.accept;
  assign in_i.ready = cmd_i.accept;
  assign full      = count_q >= CntW'(MAX_ENTRIES);
  assign teeth_sat = (teeth_cfg_q > swc_pkg::TeethW'(MAX_TEETH)) ?
                     swc_pkg::TeethW'(MAX_TEETH) : teeth_cfg_q;

  // running total saturates at the top of its range
  assign tsum    = {1'b0, total_q} + (swc_pkg::StepW + 1)'(in_i.weight);
  assign total_d = tsum[swc_pkg::StepW] ? swc_pkg::TotalMax : tsum[swc_pkg::StepW-1:0];

  assign csum  = {1'b0, cum_q} + (swc_pkg::ThrW + 1)'(rdata_q);
  assign cum_d = csum[swc_pkg::ThrW] ? {swc_pkg::ThrW{1'b1}} : csum[swc_pkg::ThrW-1:0];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      teeth_cfg_q <= swc_pkg::TeethReset;
    end else if (cfg_i.valid) begin
      teeth_cfg_q <= cfg_i.teeth_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clr_set) begin
      count_q <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (fire) begin
      if (!full) begin
        count_q <= count_q + 1'b1;
        total_q <= total_d;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !full) begin
      mem_q[count_q[AW-1:0]] <= in_i.weight;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  swc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (teeth_sat),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (fire && in_i.last_item) begin
      frac_q <= in_i.random_fraction;
    end
    if (cmd_i.mul) begin
      step_q <= quot;
      prod_q <= swc_pkg::ProdW'(frac_q) * swc_pkg::ProdW'(quot);
    end
    if (cmd_i.walk_init) begin
      thr_q    <= {1'b0, prod_q[swc_pkg::ProdW-1:swc_pkg::FracW]};
      cum_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.rd) begin
        sel_q    <= rd_idx_q;
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.add) begin
        cum_q <= cum_d;
      end
      if (cmd_i.emit) begin
        thr_q <= thr_q + {1'b0, step_q};
      end
    end
  end

  // tooth count returns to zero at the start of each walk and whenever a set is closed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tooth_q <= '0;
    end else if (cmd_i.walk_init || cmd_i.clr_set) begin
      tooth_q <= '0;
    end else if (cmd_i.emit) begin
      tooth_q <= tooth_q + 1'b1;
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign sel_wide   = IW'(sel_q);
  assign last_tooth = (tooth_q + 1'b1) == teeth_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.kind)
        swc_pkg::EMIT_WALK: begin
          out_idx_q  <= sel_wide[swc_pkg::IdxOutW-1:0];
          out_w_q    <= step_q;
          out_last_q <= last_tooth;
          out_st_q   <= ovf_q ? swc_pkg::StOvf : swc_pkg::StOk;
        end
        swc_pkg::EMIT_REPEAT: begin
          // repeat of the previous selection, index already held
          out_w_q    <= step_q;
          out_last_q <= last_tooth;
          out_st_q   <= ovf_q ? swc_pkg::StOvf : swc_pkg::StOk;
        end
        swc_pkg::EMIT_EMPTY: begin
          out_idx_q  <= '0;
          out_w_q    <= '0;
          out_last_q <= 1'b1;
          out_st_q   <= swc_pkg::StEmpty;
        end
        default: begin
          out_st_q <= swc_pkg::StEmpty;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.source_index = out_idx_q;
  assign out_o.tooth_weight = out_w_q;
  assign out_o.last_result  = out_last_q;
  assign out_o.status       = out_st_q;

  assign sts_o.last_fire  = fire && in_i.last_item;
  assign sts_o.teeth_zero = teeth_sat == '0;
  assign sts_o.total_zero = total_q == '0;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.rd_more    = rd_idx_q < count_q;
  assign sts_o.tooth_lt   = tooth_q < teeth_sat;
  assign sts_o.tooth_zero = tooth_q == '0;
  assign sts_o.hit        = thr_q < cum_q;
  assign sts_o.out_free   = out_free;

  `SWC_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(MAX_ENTRIES), "store count beyond capacity")
  `SWC_ASSERT(a_emit_free, clk_i, rst_ni, cmd_i.emit |-> out_free, "result written over a waiting one")
  `SWC_NEVER(a_tooth_bound, clk_i, rst_ni, tooth_q > teeth_sat, "more teeth than requested")
  `SWC_NEVER(a_load_vs_comb, clk_i, rst_ni, cmd_i.accept && (cmd_i.emit || cmd_i.rd), "weight taken during comb")

endmodule

// ===== sv/swc_ctrl.sv =====
// Controller: sequences load, division, offset, comb walk and result emission
module swc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swc_pkg::sts_t  sts_i,
  output swc_pkg::cmd_t  cmd_o
);

  swc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swc_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swc_pkg::S_LOAD: begin
        if (sts_i.last_fire) state_d = swc_pkg::S_CHECK;
      end
      swc_pkg::S_CHECK: begin
        if (sts_i.teeth_zero || sts_i.total_zero) state_d = swc_pkg::S_EMPTY;
        else state_d = swc_pkg::S_DIV_START;
      end
      swc_pkg::S_DIV_START: state_d = swc_pkg::S_DIV_WAIT;
      swc_pkg::S_DIV_WAIT: begin
        if (!sts_i.div_busy) state_d = swc_pkg::S_MUL;
      end
      swc_pkg::S_MUL:  state_d = swc_pkg::S_INIT;
      swc_pkg::S_INIT: state_d = swc_pkg::S_RD;
      swc_pkg::S_RD: begin
        priority if (!sts_i.tooth_lt) state_d = swc_pkg::S_FILL;
        else if (sts_i.rd_more)       state_d = swc_pkg::S_ADD;
        else if (sts_i.tooth_zero)    state_d = swc_pkg::S_EMPTY;
        else                          state_d = swc_pkg::S_FILL;
      end
      swc_pkg::S_ADD: state_d = swc_pkg::S_CMP;
      swc_pkg::S_CMP: begin
        priority if (!sts_i.tooth_lt) state_d = swc_pkg::S_FILL;
        else if (!sts_i.hit)          state_d = swc_pkg::S_RD;
        else                          state_d = swc_pkg::S_CMP;
      end
      swc_pkg::S_FILL: begin
        if (!sts_i.tooth_lt) state_d = swc_pkg::S_LOAD;
      end
      swc_pkg::S_EMPTY: begin
        if (sts_i.out_free) state_d = swc_pkg::S_LOAD;
      end
      default: state_d = swc_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = swc_pkg::EMIT_WALK;
    unique case (state_q)
      swc_pkg::S_LOAD:      cmd_o.accept    = 1'b1;
      swc_pkg::S_CHECK:     cmd_o.accept    = 1'b0;
      swc_pkg::S_DIV_START: cmd_o.div_start = 1'b1;
      swc_pkg::S_DIV_WAIT:  cmd_o.accept    = 1'b0;
      swc_pkg::S_MUL:       cmd_o.mul       = 1'b1;
      swc_pkg::S_INIT:      cmd_o.walk_init = 1'b1;
      swc_pkg::S_RD: begin
        cmd_o.rd = sts_i.tooth_lt && sts_i.rd_more;
      end
      swc_pkg::S_ADD:       cmd_o.add       = 1'b1;
      swc_pkg::S_CMP: begin
        cmd_o.emit = sts_i.tooth_lt && sts_i.hit && sts_i.out_free;
        cmd_o.kind = swc_pkg::EMIT_WALK;
      end
      swc_pkg::S_FILL: begin
        cmd_o.clr_set = !sts_i.tooth_lt;
        cmd_o.emit    = sts_i.tooth_lt && sts_i.out_free;
        cmd_o.kind    = swc_pkg::EMIT_REPEAT;
      end
      swc_pkg::S_EMPTY: begin
        cmd_o.emit    = sts_i.out_free;
        cmd_o.clr_set = sts_i.out_free;
        cmd_o.kind    = swc_pkg::EMIT_EMPTY;
      end
      default: cmd_o.accept = 1'b0;
    endcase
  end

endmodule
